[rtl/cfq_pkg.sv]
`default_nettype none

package cfq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_COUNT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [31:0] ADDR_CAPACITY = 32'd0;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [4:0]         count;
    } t_out;

    typedef struct packed {
        logic load;   // capture the pushed word
        logic shift;  // take the neighbor's word toward the head
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/cfq_cell.sv]
`default_nettype none

module cfq_cell (
    input  wire                                   i_clk,
    input  wire cfq_pkg::t_cell_ctrl              i_ctrl,
    input  wire logic signed [cfq_pkg::WORD_W-1:0] i_value,
    input  wire logic signed [cfq_pkg::WORD_W-1:0] i_next,
    output logic signed [cfq_pkg::WORD_W-1:0]      o_data
);
    import cfq_pkg::*;

    logic signed [WORD_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.load) begin
            r_data <= i_value;
        end else if (i_ctrl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/circular_fifo_queue.sv]
// circular_fifo_queue: FIFO of signed 32-bit words, built as a row of word cells.
// Input channel (i_valid/o_ready, i_in) carries one operation per transaction:
// push i_in.value, pop the oldest word, peek at it, or read the count.
// Output channel (o_valid/i_ready, o_out) returns one result per operation:
// the popped or peeked word (-1 when empty, 0 otherwise), a status code
// (ok, push refused because full, pop/peek on empty) and the count afterwards.
// The result is registered at the edge that takes the operation. Throughput is
// one operation per cycle while results are taken; the cell row updates in the
// same edge (push loads the cell at the count, pop shifts every cell one place
// toward the head, so cell 0 always holds the oldest word).
// The APB port holds one register, capacity, at address 0, which stores only
// pwdata[4:0]; 0 acts as 1, 17 to 31 act as 16. Writing it empties the queue.
// Reset empties the queue, sets capacity to 16 and drops the output valid.
// Stored words are not cleared. When the receiver stalls, the result holds and
// o_ready drops until it is taken; a taken result frees the slot in that cycle.
`default_nettype none

module circular_fifo_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire cfq_pkg::t_in i_in,
    output logic             o_valid,
    input  wire              i_ready,
    output cfq_pkg::t_out    o_out,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cfq_pkg::*;

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_out             r_out;
    t_out             n_out;

    logic             take;
    logic             cfg_wr;
    logic [CNT_W-1:0] eff_cap;
    logic             is_full;
    logic             is_empty;
    logic             do_push;
    logic             do_pop;

    logic signed [WORD_W-1:0] cell_data [DEPTH];
    t_cell_ctrl               cell_ctrl [DEPTH];

    assign pready  = 1'b1;
    assign prdata  = {{(32 - CNT_W){1'b0}}, r_cap};
    assign cfg_wr  = psel && penable && pwrite && (32'(paddr) == ADDR_CAPACITY);

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        priority if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    assign is_full  = (r_count >= eff_cap);
    assign is_empty = (r_count == '0);
    assign do_push  = take && (t_func'(i_in.func) == FUNC_PUSH) && !is_full;
    assign do_pop   = take && (t_func'(i_in.func) == FUNC_POP) && !is_empty;

    always_comb begin
        n_count    = r_count;
        n_out.data = '0;
        n_out.status = ST_OK;
        unique case (t_func'(i_in.func))
            FUNC_PUSH: begin
                if (is_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (is_empty) begin
                    n_out.data   = '1;
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.data = cell_data[0];
                    if (t_func'(i_in.func) == FUNC_POP) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            FUNC_COUNT: begin
            end
            default: begin
            end
        endcase
        n_out.count = n_count;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] next_word;

        if (g == DEPTH - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_mid
            assign next_word = cell_data[g + 1];
        end

        assign cell_ctrl[g].load  = do_push && (r_count[IDX_W-1:0] == IDX_W'(g));
        assign cell_ctrl[g].shift = do_pop;

        cfq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[g]),
            .i_value (i_in.value),
            .i_next  (next_word),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CNT_W'(DEPTH);
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cap   <= pwdata[CNT_W-1:0];
                r_count <= '0;
            end else if (take) begin
                r_count <= n_count;
            end
            if (take) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

[rtl/cfq_checker.sv]
`default_nettype none

module cfq_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_valid,
    input wire                i_ready,
    input wire cfq_pkg::t_out o_out
);
    import cfq_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == ST_FULL |-> o_out.data == 0 && o_out.count != 0)
        else $error("refused push reports wrong data or count");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status == ST_EMPTY |-> o_out.data == -1 && o_out.count == 0)
        else $error("empty pop or peek reports wrong data or count");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.count <= DEPTH && o_out.status != 2'd3)
        else $error("result count or status out of range");

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);

`default_nettype wire
